// ----- rtl/core/bstk_pkg.sv -----
// bstk_pkg: shared constants, types and state encoding for the sorted top-k list
// used by bstk_ctrl and bounded_sorted_topk_insert; no dependencies
package bstk_pkg;

    // built storage
    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // port field widths
    localparam int KEY_IN_W   = 32;
    localparam int INDEX_W    = 4;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_DATA_W-1:0] CAP_RESET = CFG_DATA_W'(16);

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] cap;
        logic             descending;
        logic             cap_wr;
        logic [CNT_W-1:0] cap_new;
    } cfg_t;

    typedef struct packed {
        logic                accepted;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count_after;
        logic                read_valid;
        logic [KEY_IN_W-1:0] read_key;
    } result_t;

endpackage

// ----- rtl/core/bstk_ram.sv -----
// bstk_ram: generic single write port, single read port ram with registered read
// no dependencies
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bstk_ctrl.sv -----
// bstk_ctrl: sequencer, shared key comparator and entry store for the top-k list
// depends on bstk_pkg and bstk_ram
module bstk_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bstk_pkg::cfg_t                  cfg_i,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_func,
    input  logic [bstk_pkg::KEY_IN_W-1:0]   in_key,
    input  logic [bstk_pkg::INDEX_W-1:0]    in_index,
    output logic                            res_valid,
    input  logic                            res_ready,
    output bstk_pkg::result_t               res_o
);

    bstk_pkg::state_t state_reg, state_next;

    logic [bstk_pkg::CNT_W-1:0]     count_reg;
    logic [bstk_pkg::CNT_W-1:0]     idx_reg;
    logic [bstk_pkg::CNT_W-1:0]     ptr_reg;
    logic [bstk_pkg::KEY_WIDTH-1:0] key_reg;
    logic [bstk_pkg::INDEX_W-1:0]   index_reg;
    logic                           accepted_reg;
    logic                           rvalid_reg;
    logic [bstk_pkg::KEY_WIDTH-1:0] rkey_reg;

    logic [bstk_pkg::CNT_W-1:0]     idx_inc;
    logic [bstk_pkg::CNT_W-1:0]     ptr_dec;
    logic [bstk_pkg::KEY_WIDTH-1:0] cmp_lhs, cmp_rhs;
    logic                           goes_before;
    logic                           read_hit;

    logic                           wr_en;
    logic [bstk_pkg::ADDR_W-1:0]    wr_addr;
    logic [bstk_pkg::KEY_WIDTH-1:0] wr_data;
    logic [bstk_pkg::ADDR_W-1:0]    rd_addr;
    logic [bstk_pkg::KEY_WIDTH-1:0] rd_data;

    bstk_ram #(
        .WIDTH (bstk_pkg::KEY_WIDTH),
        .DEPTH (bstk_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_inc  = idx_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign read_hit = bstk_pkg::CNT_W'(in_index) < count_reg;

    // one comparator, operands swapped for descending order
    assign cmp_lhs     = cfg_i.descending ? key_reg : rd_data;
    assign cmp_rhs     = cfg_i.descending ? rd_data : key_reg;
    assign goes_before = cmp_lhs < cmp_rhs;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bstk_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_func == bstk_pkg::FUNC_READ) begin
                        state_next = read_hit ? bstk_pkg::ST_READ_RD : bstk_pkg::ST_DONE;
                    end else begin
                        state_next = (count_reg == '0) ? bstk_pkg::ST_DECIDE
                                                       : bstk_pkg::ST_SCAN;
                    end
                end
            end
            bstk_pkg::ST_SCAN: begin
                state_next = bstk_pkg::ST_CMP;
            end
            bstk_pkg::ST_CMP: begin
                if (goes_before && (idx_inc < count_reg)) begin
                    state_next = bstk_pkg::ST_SCAN;
                end else begin
                    state_next = bstk_pkg::ST_DECIDE;
                end
            end
            bstk_pkg::ST_DECIDE: begin
                state_next = (idx_reg < cfg_i.cap) ? bstk_pkg::ST_SHIFT_RD : bstk_pkg::ST_DONE;
            end
            bstk_pkg::ST_SHIFT_RD: begin
                state_next = (ptr_reg > idx_reg) ? bstk_pkg::ST_SHIFT_WR : bstk_pkg::ST_PUT;
            end
            bstk_pkg::ST_SHIFT_WR: begin
                state_next = bstk_pkg::ST_SHIFT_RD;
            end
            bstk_pkg::ST_PUT: begin
                state_next = bstk_pkg::ST_DONE;
            end
            bstk_pkg::ST_READ_RD: begin
                state_next = bstk_pkg::ST_READ_WAIT;
            end
            bstk_pkg::ST_READ_WAIT: begin
                state_next = bstk_pkg::ST_DONE;
            end
            bstk_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = bstk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bstk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg[bstk_pkg::ADDR_W-1:0];
        wr_data   = key_reg;
        rd_addr   = idx_reg[bstk_pkg::ADDR_W-1:0];
        case (state_reg)
            bstk_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            bstk_pkg::ST_SHIFT_RD: begin
                rd_addr = ptr_dec[bstk_pkg::ADDR_W-1:0];
            end
            bstk_pkg::ST_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[bstk_pkg::ADDR_W-1:0];
                wr_data = rd_data;
            end
            bstk_pkg::ST_PUT: begin
                wr_en = 1'b1;
            end
            bstk_pkg::ST_READ_RD: begin
                rd_addr = bstk_pkg::ADDR_W'(index_reg);
            end
            bstk_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bstk_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == bstk_pkg::ST_DECIDE && idx_reg < cfg_i.cap
                    && count_reg < cfg_i.cap) begin
                count_reg <= count_reg + 1'b1;
            end
            // lowering the capacity trims the list
            if (cfg_i.cap_wr && count_reg > cfg_i.cap_new) begin
                count_reg <= cfg_i.cap_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            bstk_pkg::ST_IDLE: begin
                key_reg      <= in_key[bstk_pkg::KEY_WIDTH-1:0];
                index_reg    <= in_index;
                idx_reg      <= '0;
                accepted_reg <= 1'b0;
                rvalid_reg   <= 1'b0;
                rkey_reg     <= '0;
            end
            bstk_pkg::ST_CMP: begin
                if (goes_before) begin
                    idx_reg <= idx_inc;
                end
            end
            bstk_pkg::ST_DECIDE: begin
                // last place of the list after this insert
                ptr_reg <= (count_reg < cfg_i.cap) ? count_reg : count_reg - 1'b1;
            end
            bstk_pkg::ST_SHIFT_WR: begin
                ptr_reg <= ptr_dec;
            end
            bstk_pkg::ST_PUT: begin
                accepted_reg <= 1'b1;
            end
            bstk_pkg::ST_READ_WAIT: begin
                rvalid_reg <= 1'b1;
                rkey_reg   <= rd_data;
            end
            default: begin
                accepted_reg <= accepted_reg;
            end
        endcase
    end

    assign res_o.accepted    = accepted_reg;
    assign res_o.position    = accepted_reg ? bstk_pkg::POS_W'(idx_reg) : '0;
    assign res_o.count_after = bstk_pkg::COUNT_W'(count_reg);
    assign res_o.read_valid  = rvalid_reg;
    assign res_o.read_key    = bstk_pkg::KEY_IN_W'(rkey_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bstk_pkg::CNT_W'(bstk_pkg::DEPTH))
        else $error("list count beyond depth");

    a_write_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> bstk_pkg::CNT_W'(wr_addr) < count_reg)
        else $error("store written outside the list");

    a_pos_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_o.accepted) |-> res_o.position < res_o.count_after)
        else $error("inserted position beyond count");

    a_insert_not_read: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res_o.accepted && res_o.read_valid))
        else $error("word flags both insert and read");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> in_ready)
        else $error("sequencer did not return to idle");

endmodule

// ----- rtl/core/bounded_sorted_topk_insert.sv -----
// bounded_sorted_topk_insert: top level with config registers and output register
// depends on bstk_pkg and bstk_ctrl
// insert: stored keys are compared in turn, entries past its place move up, then the key is
//   written, or a dropped key goes straight to the result; read: a ram read, skipped
//   at or past count; one word at a time, the next taken after its result is registered
// reset: synchronous active-low aresetn empties the list, capacity 16, ascending
module bounded_sorted_topk_insert (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bstk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bstk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [bstk_pkg::KEY_IN_W-1:0]     s_key,
    input  logic [bstk_pkg::INDEX_W-1:0]      s_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_accepted,
    output logic [bstk_pkg::POS_W-1:0]        m_position,
    output logic [bstk_pkg::COUNT_W-1:0]      m_count_after,
    output logic                              m_read_valid,
    output logic [bstk_pkg::KEY_IN_W-1:0]     m_read_key
);

    logic [bstk_pkg::CFG_DATA_W-1:0] cap_reg;
    logic                            desc_reg;
    logic                            m_valid_reg;
    bstk_pkg::result_t               res_reg;

    bstk_pkg::cfg_t    cfg;
    bstk_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // capacity above the built depth acts as the depth
    assign cfg.cap = (cap_reg > bstk_pkg::CFG_DATA_W'(bstk_pkg::DEPTH))
                   ? bstk_pkg::CNT_W'(bstk_pkg::DEPTH) : bstk_pkg::CNT_W'(cap_reg);
    assign cfg.descending = desc_reg;
    assign cfg.cap_wr     = cfg_wr && (cfg_index == bstk_pkg::CFG_CAPACITY);
    assign cfg.cap_new = (cfg_data > bstk_pkg::CFG_DATA_W'(bstk_pkg::DEPTH))
                       ? bstk_pkg::CNT_W'(bstk_pkg::DEPTH) : bstk_pkg::CNT_W'(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= bstk_pkg::CAP_RESET;
            desc_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                bstk_pkg::CFG_CAPACITY: begin
                    cap_reg <= cfg_data;
                end
                bstk_pkg::CFG_DESCENDING: begin
                    desc_reg <= cfg_data[0];
                end
                default: begin
                    cap_reg <= cap_reg;
                end
            endcase
        end
    end

    bstk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_key    (s_key),
        .in_index  (s_index),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_o     (res)
    );

    // output word register takes one result while the sink stalls, freeing the sequencer
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = res_reg.accepted;
    assign m_position    = res_reg.position;
    assign m_count_after = res_reg.count_after;
    assign m_read_valid  = res_reg.read_valid;
    assign m_read_key    = res_reg.read_key;

endmodule

// ----- tb/sv/bounded_sorted_topk_insert_test.sv -----
// bounded_sorted_topk_insert_test: self-checking bench for the sorted top-k list block
// drives inserts, reads and register writes, and checks every result word against a shadow list
// depends on bstk_pkg and bounded_sorted_topk_insert
module bounded_sorted_topk_insert_test;
    import bstk_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

    class sorted_list_shadow;
        logic [KEY_WIDTH-1:0] slots [DEPTH];
        int      stored = 0;
        int      cap_reg = 16;
        bit      desc_reg = 1'b0;
        result_t pending_results [$];
        int      errors = 0;

        function int eff_cap();
            return (cap_reg > DEPTH) ? DEPTH : cap_reg;
        endfunction

        function bit goes_ahead(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
            return desc_reg ? (a > b) : (a < b);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CAPACITY) begin
                cap_reg = int'(data);
                // lowering the capacity throws away the tail of the list
                if (stored > eff_cap())
                    stored = eff_cap();
            end else begin
                desc_reg = data[0];
            end
        endfunction

        function void take_item(logic f, logic [KEY_IN_W-1:0] key, logic [INDEX_W-1:0] ix);
            result_t want;
            int      pos;
            int      i;
            want = '0;
            if (f == FUNC_INSERT) begin
                pos = 0;
                while (pos < stored && pos < DEPTH && goes_ahead(slots[pos], key))
                    pos++;
                if (pos < eff_cap()) begin
                    if (stored < eff_cap())
                        stored++;
                    for (i = stored - 1; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos] = key;
                    want.accepted = 1'b1;
                    want.position = POS_W'(pos);
                end
            end else if (int'(ix) < stored) begin
                want.read_valid = 1'b1;
                want.read_key = slots[ix];
            end
            want.count_after = COUNT_W'(stored);
            pending_results.push_back(want);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            cmp_field("accepted", 32'(want.accepted), 32'(got.accepted));
            cmp_field("position", 32'(want.position), 32'(got.position));
            cmp_field("count_after", 32'(want.count_after), 32'(got.count_after));
            cmp_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
            cmp_field("read_key", 32'(want.read_key), 32'(got.read_key));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_func;
    logic [KEY_IN_W-1:0]   s_key;
    logic [INDEX_W-1:0]    s_index;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_accepted;
    logic [POS_W-1:0]      m_position;
    logic [COUNT_W-1:0]    m_count_after;
    logic                  m_read_valid;
    logic [KEY_IN_W-1:0]   m_read_key;

    sorted_list_shadow shadow;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    bounded_sorted_topk_insert u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key         (s_key),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_position    (m_position),
        .m_count_after (m_count_after),
        .m_read_valid  (m_read_valid),
        .m_read_key    (m_read_key)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random back-pressure, or a long hold-off on request
    initial begin : sink
        int stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.accepted = m_accepted;
            got.position = m_position;
            got.count_after = m_count_after;
            got.read_valid = m_read_valid;
            got.read_key = m_read_key;
            shadow.check_word(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high from one word to the next unless an idle cycle is taken
    task automatic send(input logic f, input logic [KEY_IN_W-1:0] key,
                        input logic [INDEX_W-1:0] ix);
        while (!calm && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_key <= key;
        s_index <= ix;
        do @(posedge aclk); while (s_ready !== 1'b1);
        shadow.take_item(f, key, ix);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // both registers in one burst so cfg_valid is never dropped and raised in one step
    task automatic set_mode(input logic [CFG_DATA_W-1:0] cap, input bit desc);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data <= cap;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        shadow.write_reg(CFG_CAPACITY, cap);
        cfg_index <= CFG_DESCENDING;
        cfg_data <= CFG_DATA_W'(desc);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        shadow.write_reg(CFG_DESCENDING, CFG_DATA_W'(desc));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_items(input int n);
        int                  k;
        int                  pick;
        logic                f;
        logic [KEY_IN_W-1:0] key;
        logic [INDEX_W-1:0]  ix;
        for (k = 0; k < n; k++) begin
            f = ($urandom_range(99) < 35) ? FUNC_READ : FUNC_INSERT;
            pick = $urandom_range(9);
            if (pick < 5)
                key = $urandom;
            else if (pick < 8)
                key = $urandom_range(15);           // many equal keys
            else if (pick == 8)
                key = $urandom_range(1) ? '1 : '0;
            else
                key = 32'hFFFF_FFF0 | $urandom_range(15);
            if (shadow.stored > 0 && $urandom_range(9) < 7)
                ix = INDEX_W'($urandom_range(shadow.stored - 1));
            else
                ix = INDEX_W'($urandom);
            send(f, key, ix);
        end
    endtask

    initial begin : main
        int i;
        shadow = new;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CAPACITY;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_func <= FUNC_INSERT;
        s_key <= '0;
        s_index <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: capacity 16, ascending
        send(FUNC_READ, '0, 4'd0);                  // empty list
        send(FUNC_READ, '0, 4'd15);
        send(FUNC_INSERT, 32'd100, '0);
        send(FUNC_INSERT, 32'd0, '0);
        send(FUNC_INSERT, 32'hFFFF_FFFF, '0);
        send(FUNC_INSERT, 32'd100, '0);             // equal key lands ahead
        send(FUNC_INSERT, 32'd50, '0);
        send(FUNC_READ, '0, 4'd0);
        send(FUNC_READ, '0, 4'd2);
        send(FUNC_READ, '0, 4'd4);
        send(FUNC_READ, '0, 4'd5);                  // at count
        for (i = 0; i < 11; i++)
            send(FUNC_INSERT, 32'd200 + 32'(i * 7), '0);
        send(FUNC_INSERT, 32'd1, '0);               // full list, last entry falls off
        send(FUNC_READ, '0, 4'd15);

        // capacity above depth, descending
        set_mode(5'd31, 1'b1);
        run_items(250);

        // capacity cut far below the count
        set_mode(5'd1, 1'b0);
        send(FUNC_READ, '0, 4'd0);
        send(FUNC_READ, '0, 4'd1);
        send(FUNC_INSERT, 32'hFFFF_FFFF, '0);
        send(FUNC_INSERT, 32'd0, '0);
        run_items(100);

        // no place in use
        set_mode(5'd0, 1'b0);
        run_items(60);

        // full depth: calm stretch, then a long hold-off on the result side
        set_mode(5'd16, 1'b0);
        calm = 1'b1;
        run_items(150);
        calm = 1'b0;
        hold_req = 1'b1;
        run_items(150);

        set_mode(5'd3, 1'b1);
        run_items(100);

        for (i = 0; i < 4; i++) begin
            set_mode(CFG_DATA_W'($urandom_range(1, 31)), 1'($urandom_range(1)));
            run_items(100);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bstk_pkg.sv
rtl/core/bstk_ram.sv
rtl/core/bstk_ctrl.sv
rtl/core/bounded_sorted_topk_insert.sv
tb/sv/bounded_sorted_topk_insert_test.sv
